### hdl/mwe_pkg.sv
// ----------------------------------------------------------------------------
// mwe_pkg
// Shared widths, reset values, register codes and the result layout of the
// mask window erosion block.
// ----------------------------------------------------------------------------
package mwe_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_RADIUS = 15;

    localparam int PW_W   = 12;
    localparam int RAD_W  = 4;
    localparam int CS_W   = 5;
    localparam int SUM_W  = 10;
    localparam int CCOL_W = 11;
    localparam int ROW_W  = 12;

    localparam logic [PW_W-1:0]  RST_PADDED_WIDTH = 12'd1110;
    localparam logic [RAD_W-1:0] RST_RADIUS       = 4'd10;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;

    localparam int OUT_DEPTH = 3;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        REG_PADDED_WIDTH = 1'b0,
        REG_RADIUS       = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [ROW_W-1:0]  centre_row;
        logic [CCOL_W-1:0] centre_col;
        logic              window_full;
        logic [SUM_W-1:0]  window_sum;
    } result_t;

    localparam int RESULT_W  = $bits(result_t);
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

### hdl/mask_window_erosion_top.sv
// ----------------------------------------------------------------------------
// mask_window_erosion_top
// Square window box sum and binary erosion over a zero padded mask stream,
// using a ring of row bits and per-column running sums.
// ----------------------------------------------------------------------------
//  channel  | kind       | payload
//  ---------+------------+-----------------------------------------------------
//  s_*      | stream in  | tdata[0] mask_bit, tuser[0] frame_start
//  m_*      | stream out | tdata window_sum, window_full, centre_col, centre_row
//  p*       | apb        | 0x0 padded_width, 0x4 radius
//
//  one item per cycle sustained while s_tready holds high; a result is put
//  into the output buffer after its memory read and column and window sum update
//  column sums are cleared at frame start through a fill count, no sweep
//  a three entry output buffer takes results while m_tready is low; s_tready
//  drops once two results wait and one more item is in flight
// ----------------------------------------------------------------------------
module mask_window_erosion_top #(
    parameter int MAX_WIDTH  = mwe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = mwe_pkg::DEF_MAX_RADIUS
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mwe_pkg::APB_AW-1:0]      paddr,
    input  logic [mwe_pkg::APB_DW-1:0]      pwdata,
    output logic [mwe_pkg::APB_DW-1:0]      prdata,
    output logic                            pready,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mwe_pkg::S_TDATA_W-1:0]   s_tdata,    // [0] mask_bit
    input  logic [mwe_pkg::S_TUSER_W-1:0]   s_tuser,    // [0] frame_start

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mwe_pkg::M_TDATA_W-1:0]   m_tdata     // [9:0] window_sum, [10] window_full,
                                                        // [21:11] centre_col, [33:22] centre_row
);

    localparam int RING     = 2 * MAX_RADIUS + 1;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CNT_W    = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W   = (CNT_W > mwe_pkg::PW_W) ? CNT_W : mwe_pkg::PW_W;
    localparam int RCMP_W   = ($clog2(MAX_RADIUS + 1) > mwe_pkg::RAD_W) ?
                              $clog2(MAX_RADIUS + 1) : mwe_pkg::RAD_W;
    localparam int D_W      = mwe_pkg::RAD_W + 1;
    localparam int SLOT_W   = $clog2(RING);
    localparam int OS_W     = SLOT_W + 1;
    localparam int RS_DEPTH = RING * MAX_WIDTH;
    localparam int RS_AW    = $clog2(RS_DEPTH);

    typedef struct packed {
        logic [COL_W-1:0]               col;
        logic                           mask;
        logic                           row_ge_d;
        logic                           col_zero;
        logic                           col_ge_d;
        logic                           emit;
        logic                           v0;
        logic                           v1;
        logic                           hit0;
        logic                           hit1;
        logic [mwe_pkg::CS_W-1:0]       byp0;
        logic [mwe_pkg::CS_W-1:0]       byp1;
        logic [mwe_pkg::SUM_W-1:0]      dd;
        logic [mwe_pkg::CCOL_W-1:0]     centre_col;
        logic [mwe_pkg::ROW_W-1:0]      centre_row;
    } stage_t;

    function automatic logic [SLOT_W-1:0] slot_adv(input logic [mwe_pkg::ROW_W-1:0] r,
                                                   input logic [SLOT_W-1:0] s);
        if (r == '1 || s == SLOT_W'(RING - 1))
        begin
            slot_adv = '0;
        end
        else
        begin
            slot_adv = s + 1'b1;
        end
    endfunction

    // configuration
    logic [mwe_pkg::PW_W-1:0]   pw_reg;
    logic [mwe_pkg::RAD_W-1:0]  rad_reg;
    logic                       cfg_wr;
    mwe_pkg::reg_idx_t          cfg_idx;

    // effective settings
    logic [WCMP_W-1:0]          pw_ext;
    logic [CNT_W-1:0]           w_eff;
    logic [RCMP_W-1:0]          rad_ext;
    logic [mwe_pkg::RAD_W-1:0]  r_eff;
    logic [D_W-1:0]             d;
    logic [D_W-1:0]             two_r;
    logic [mwe_pkg::SUM_W-1:0]  dd;

    // position
    logic                       s_acc;
    logic                       mask_bit;
    logic                       frame_start;
    logic [COL_W-1:0]           col_reg, col_next, col0, col_c, col_sub;
    logic [mwe_pkg::ROW_W-1:0]  row_reg, row_next, row0, row_c;
    logic [SLOT_W-1:0]          slot_reg, slot_next, slot0, slot_c, old_slot;
    logic [CNT_W-1:0]           fill_reg, fill_next, fill0, col_inc;
    logic [OS_W-1:0]            os_sum;
    logic [RS_AW-1:0]           rs_waddr, rs_raddr;

    // stage one
    stage_t                     s1_reg, s1_next;
    logic                       s1_valid_reg;
    logic                       rs_q_reg;
    logic [mwe_pkg::CS_W-1:0]   cs_q0_reg, cs_q1_reg;
    logic [mwe_pkg::CS_W-1:0]   cs_rd, cs_old, cs_new, cs_sub;
    logic [mwe_pkg::SUM_W-1:0]  rws_reg, rws_next, rws_base;
    mwe_pkg::result_t           res;
    logic                       push;

    // memories
    logic                       rs_mem [RS_DEPTH];
    logic [mwe_pkg::CS_W-1:0]   cs_mem [MAX_WIDTH];

    // output buffer
    mwe_pkg::result_t           ob_reg [mwe_pkg::OUT_DEPTH];
    logic [mwe_pkg::OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mwe_pkg::OUT_CNT_W-1:0] occ_reg, occ_next;
    logic                       pop;

    // ------------------------------------------------------------------------
    // apb registers
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = mwe_pkg::reg_idx_t'(paddr[mwe_pkg::APB_AW-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg  <= mwe_pkg::RST_PADDED_WIDTH;
            rad_reg <= mwe_pkg::RST_RADIUS;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                mwe_pkg::REG_PADDED_WIDTH: pw_reg  <= pwdata[mwe_pkg::PW_W-1:0];
                mwe_pkg::REG_RADIUS:       rad_reg <= pwdata[mwe_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            mwe_pkg::REG_PADDED_WIDTH:
                prdata = {{(mwe_pkg::APB_DW - mwe_pkg::PW_W){1'b0}}, pw_reg};
            mwe_pkg::REG_RADIUS:
                prdata = {{(mwe_pkg::APB_DW - mwe_pkg::RAD_W){1'b0}}, rad_reg};
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // clamped width and radius
    // ------------------------------------------------------------------------
    assign pw_ext  = WCMP_W'(pw_reg);
    assign rad_ext = RCMP_W'(rad_reg);

    always_comb
    begin
        if (pw_reg == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (pw_ext > WCMP_W'(MAX_WIDTH))
        begin
            w_eff = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CNT_W'(pw_ext);
        end
    end

    assign r_eff = (rad_ext > RCMP_W'(MAX_RADIUS)) ? mwe_pkg::RAD_W'(MAX_RADIUS) : rad_reg;
    assign d     = {r_eff, 1'b1};
    assign two_r = {r_eff, 1'b0};
    assign dd    = mwe_pkg::SUM_W'(d) * mwe_pkg::SUM_W'(d);

    // ------------------------------------------------------------------------
    // position tracking at accept
    // ------------------------------------------------------------------------
    assign s_acc       = s_tvalid && s_tready;
    assign mask_bit    = s_tdata[0];
    assign frame_start = s_tuser[0];

    always_comb
    begin
        col0  = frame_start ? '0 : col_reg;
        row0  = frame_start ? '0 : row_reg;
        slot0 = frame_start ? '0 : slot_reg;
        fill0 = frame_start ? '0 : fill_reg;

        // width lowered mid-row: the row ends before this pixel
        if (CNT_W'(col0) >= w_eff)
        begin
            col_c  = '0;
            row_c  = row0 + 1'b1;
            slot_c = slot_adv(row0, slot0);
        end
        else
        begin
            col_c  = col0;
            row_c  = row0;
            slot_c = slot0;
        end

        col_inc = CNT_W'(col_c) + 1'b1;
        if (col_inc >= w_eff)
        begin
            col_next  = '0;
            row_next  = row_c + 1'b1;
            slot_next = slot_adv(row_c, slot_c);
        end
        else
        begin
            col_next  = col_inc[COL_W-1:0];
            row_next  = row_c;
            slot_next = slot_c;
        end
        fill_next = (col_inc > fill0) ? col_inc : fill0;

        os_sum   = OS_W'(slot_c) + OS_W'(RING) - OS_W'(d);
        old_slot = (os_sum >= OS_W'(RING)) ? SLOT_W'(os_sum - OS_W'(RING)) : SLOT_W'(os_sum);
        rs_waddr = RS_AW'(slot_c) * RS_AW'(MAX_WIDTH) + RS_AW'(col_c);
        rs_raddr = RS_AW'(old_slot) * RS_AW'(MAX_WIDTH) + RS_AW'(col_c);
        col_sub  = COL_W'(CNT_W'(col_c) - CNT_W'(d));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else if (s_acc)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            fill_reg <= fill_next;
        end
    end

    // ------------------------------------------------------------------------
    // stage one payload
    // ------------------------------------------------------------------------
    always_comb
    begin
        s1_next.col        = col_c;
        s1_next.mask       = mask_bit;
        s1_next.row_ge_d   = row_c >= mwe_pkg::ROW_W'(d);
        s1_next.col_zero   = col_c == '0;
        s1_next.col_ge_d   = CNT_W'(col_c) >= CNT_W'(d);
        s1_next.emit       = (row_c >= mwe_pkg::ROW_W'(two_r)) &&
                             (CNT_W'(col_c) >= CNT_W'(two_r));
        s1_next.v0         = CNT_W'(col_c) < fill0;
        s1_next.v1         = CNT_W'(col_sub) < fill0;
        // sum written back this cycle by the item ahead
        s1_next.hit0       = s1_valid_reg && (s1_reg.col == col_c);
        s1_next.hit1       = s1_valid_reg && (s1_reg.col == col_sub);
        s1_next.byp0       = cs_new;
        s1_next.byp1       = cs_new;
        s1_next.dd         = dd;
        s1_next.centre_col = mwe_pkg::CCOL_W'(CNT_W'(col_c) - CNT_W'(two_r));
        s1_next.centre_row = row_c - mwe_pkg::ROW_W'(two_r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------------
    // row bit ring and column sum memories
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            rs_q_reg           <= rs_mem[rs_raddr];
            rs_mem[rs_waddr]   <= mask_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cs_q0_reg <= cs_mem[col_c];
            cs_q1_reg <= cs_mem[col_sub];
        end
        if (s1_valid_reg)
        begin
            cs_mem[s1_reg.col] <= cs_new;
        end
    end

    // ------------------------------------------------------------------------
    // column sum and window sum update
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (!s1_reg.v0)
        begin
            cs_rd = '0;
        end
        else if (s1_reg.hit0)
        begin
            cs_rd = s1_reg.byp0;
        end
        else
        begin
            cs_rd = cs_q0_reg;
        end

        if (!s1_reg.v1)
        begin
            cs_sub = '0;
        end
        else if (s1_reg.hit1)
        begin
            cs_sub = s1_reg.byp1;
        end
        else
        begin
            cs_sub = cs_q1_reg;
        end

        cs_old   = s1_reg.row_ge_d ? mwe_pkg::CS_W'(rs_q_reg) : '0;
        cs_new   = cs_rd + mwe_pkg::CS_W'(s1_reg.mask) - cs_old;
        rws_base = s1_reg.col_zero ? mwe_pkg::SUM_W'(cs_new) :
                                     rws_reg + mwe_pkg::SUM_W'(cs_new);
        rws_next = rws_base - (s1_reg.col_ge_d ? mwe_pkg::SUM_W'(cs_sub) : '0);

        res.window_sum  = rws_next;
        res.window_full = rws_next == s1_reg.dd;
        res.centre_col  = s1_reg.centre_col;
        res.centre_row  = s1_reg.centre_row;
    end

    assign push = s1_valid_reg && s1_reg.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rws_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            rws_reg <= rws_next;
        end
    end

    // ------------------------------------------------------------------------
    // output buffer
    // ------------------------------------------------------------------------
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = occ_reg != '0;
    assign m_tdata  = mwe_pkg::M_TDATA_W'(ob_reg[rd_ptr_reg]);
    assign s_tready = (mwe_pkg::OUT_CNT_W + 1)'(occ_reg) +
                      (mwe_pkg::OUT_CNT_W + 1)'(s1_valid_reg) <
                      (mwe_pkg::OUT_CNT_W + 1)'(mwe_pkg::OUT_DEPTH);

    always_comb
    begin
        occ_next = occ_reg;
        if (push && !pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ob_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == mwe_pkg::OUT_PTR_W'(mwe_pkg::OUT_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == mwe_pkg::OUT_PTR_W'(mwe_pkg::OUT_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

### hdl/mwe_checker.sv
// ----------------------------------------------------------------------------
// mwe_checker
// Port level checks of the mask window erosion block, bound to its top level.
// ----------------------------------------------------------------------------
module mwe_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mwe_pkg::M_TDATA_W-1:0]   m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // eroded pixel implies a nonzero window sum
    a_full_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[mwe_pkg::SUM_W] |-> m_tdata[mwe_pkg::SUM_W-1:0] != '0)
        else $error("window_full set with zero window_sum");

    // a result rising on m_tvalid traces back to an accepted item, through stage one and the output buffer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without an item two cycles earlier");

    // empty output side never blocks input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result waiting");

endmodule

bind mask_window_erosion_top mwe_checker u_mwe_checker (.*);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mask_window_erosion_top. Zero padded mask frames
// stream in through the slave port while a bit-exact model of the row ring,
// column sums and window sum predicts every window result. Results on the
// master port are compared field by field in order. Window geometry is set
// over apb between phases and read back. Phases cover small directed frames,
// width clamps, a narrowed row width mid-frame, the largest window, random
// frames and a long output stall.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW        = mwe_pkg::DEF_MAX_WIDTH;
    localparam int MAXR        = mwe_pkg::DEF_MAX_RADIUS;
    localparam int RING        = 2 * MAXR + 1;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PIXELS = 360;

    typedef struct packed {
        logic mask_bit;
        logic frame_start;
    } pixel_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;

    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [mwe_pkg::APB_AW-1:0]         paddr = '0;
    logic [mwe_pkg::APB_DW-1:0]         pwdata = '0;
    logic [mwe_pkg::APB_DW-1:0]         prdata;
    logic                               pready;

    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [mwe_pkg::S_TDATA_W-1:0]      s_tdata = '0;
    logic [mwe_pkg::S_TUSER_W-1:0]      s_tuser = '0;

    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [mwe_pkg::M_TDATA_W-1:0]      m_tdata;

    pixel_t                             pixel_q[$];
    mwe_pkg::result_t                   window_q[$];

    logic [mwe_pkg::PW_W-1:0]           cfg_width = mwe_pkg::RST_PADDED_WIDTH;
    logic [mwe_pkg::RAD_W-1:0]          cfg_radius = mwe_pkg::RST_RADIUS;
    bit                                 row_ring [RING * MAXW];
    bit [mwe_pkg::CS_W-1:0]             col_sums [MAXW];
    int                                 run_sum = 0;
    int                                 col_pos = 0;
    int                                 row_pos = 0;

    int                                 error_count = 0;
    int                                 queued = 0;
    int                                 pixel_count = 0;
    int                                 result_count = 0;
    int                                 full_count = 0;
    int                                 setting_count = 0;
    int                                 cycle_count = 0;
    int                                 hold_left = 0;
    bit                                 hold_done = 1'b0;
    bit                                 calm = 1'b0;

    mask_window_erosion_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void flag_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("mismatch: %s", what);
    endfunction

    // one pixel into the row ring and running sums, window result if complete
    function automatic bit erode_pixel(input logic mbit, input logic fstart,
                                       output mwe_pkg::result_t res);
        int w, rad, d, col, row, slot, oslot, cs, i;
        bit hit;
        w   = (cfg_width == 0) ? 1 : (cfg_width > MAXW) ? MAXW : int'(cfg_width);
        rad = (cfg_radius > MAXR) ? MAXR : int'(cfg_radius);
        d   = 2 * rad + 1;
        res = '0;
        hit = 1'b0;
        if (fstart) begin
            col_pos = 0;
            row_pos = 0;
            run_sum = 0;
            for (i = 0; i < MAXW; i++)
                col_sums[i] = '0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 'hFFF;
        end
        col   = col_pos % MAXW;
        row   = row_pos;
        slot  = row % RING;
        oslot = (slot + RING - d) % RING;

        cs = int'(col_sums[col]) + int'(mbit);
        if (row >= d)
            cs = cs - int'(row_ring[oslot * MAXW + col]);
        col_sums[col] = cs[mwe_pkg::CS_W-1:0];
        row_ring[slot * MAXW + col] = mbit;

        if (col == 0)
            run_sum = int'(col_sums[0]);
        else
            run_sum = run_sum + int'(col_sums[col]);
        if (col >= d)
            run_sum = run_sum - int'(col_sums[col - d]);
        run_sum = run_sum & 'h3FF;

        if (row >= d - 1 && col >= d - 1) begin
            res.window_sum  = mwe_pkg::SUM_W'(run_sum);
            res.window_full = (run_sum == d * d);
            res.centre_col  = mwe_pkg::CCOL_W'(col - 2 * rad);
            res.centre_row  = mwe_pkg::ROW_W'(row - 2 * rad);
            hit = 1'b1;
        end

        col_pos = col + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 'hFFF;
        end
        return hit;
    endfunction

    always @(posedge clk)
    begin : pixel_driver
        pixel_t           nxt;
        mwe_pkg::result_t res;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                pixel_count++;
                if (erode_pixel(s_tdata[0], s_tuser[0], res))
                    window_q.insert(window_q.size(), res);
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
                    nxt = pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= mwe_pkg::S_TDATA_W'(nxt.mask_bit);
                    s_tuser  <= mwe_pkg::S_TUSER_W'(nxt.frame_start);
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : window_monitor
        mwe_pkg::result_t got;
        mwe_pkg::result_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got = mwe_pkg::result_t'(m_tdata[mwe_pkg::RESULT_W-1:0]);
                result_count++;
                if (window_q.size() == 0) begin
                    flag_error($sformatf("result %h with no window pending", got));
                end
                else begin
                    want = window_q.pop_front();
                    if (want.window_full)
                        full_count++;
                    if (got.window_sum !== want.window_sum)
                        flag_error($sformatf("window_sum expected %0d got %0d",
                                             want.window_sum, got.window_sum));
                    if (got.window_full !== want.window_full)
                        flag_error($sformatf("window_full expected %0d got %0d",
                                             want.window_full, got.window_full));
                    if (got.centre_col !== want.centre_col)
                        flag_error($sformatf("centre_col expected %0d got %0d",
                                             want.centre_col, got.centre_col));
                    if (got.centre_row !== want.centre_row)
                        flag_error($sformatf("centre_row expected %0d got %0d",
                                             want.centre_row, got.centre_row));
                end
            end
            // long stall while the sender keeps pushing, fills the output buffer
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && pixel_q.size() > 200 && result_count > 30) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= calm || ($urandom_range(99) >= 20);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d windows pending",
                     cycle_count, window_q.size());
            $display("FAIL mask_window_erosion_top");
            $finish;
        end
    end

    task automatic apb_access(input mwe_pkg::reg_idx_t idx, input int val);
        logic [mwe_pkg::APB_DW-1:0] want;
        if (idx == mwe_pkg::REG_PADDED_WIDTH)
            want = mwe_pkg::APB_DW'(val & ((1 << mwe_pkg::PW_W) - 1));
        else
            want = mwe_pkg::APB_DW'(val & ((1 << mwe_pkg::RAD_W) - 1));
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mwe_pkg::APB_AW'(4 * int'(idx));
        pwdata  <= mwe_pkg::APB_DW'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == mwe_pkg::REG_PADDED_WIDTH)
            cfg_width = want[mwe_pkg::PW_W-1:0];
        else
            cfg_radius = want[mwe_pkg::RAD_W-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            flag_error($sformatf("register %s read back %h, expected %h",
                                 idx.name(), prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_window(input int w, input int r);
        apb_access(mwe_pkg::REG_PADDED_WIDTH, w);
        apb_access(mwe_pkg::REG_RADIUS, r);
        setting_count++;
        @(negedge clk);
    endtask

    task automatic queue_pixel(input logic b, input logic fs);
        pixel_t p;
        p.mask_bit    = b;
        p.frame_start = fs;
        pixel_q.insert(pixel_q.size(), p);
        queued++;
    endtask

    task automatic queue_frame(input int w, input int rows, input int dens,
                               input bit with_start, input int cut);
        int n, i;
        n = w * rows;
        if (cut > 0 && cut < n)
            n = cut;
        for (i = 0; i < n; i++)
            queue_pixel($urandom_range(99) < dens, with_start && i == 0);
    endtask

    task automatic settle();
        @(negedge clk);
        while (pixel_q.size() != 0 || s_tvalid || window_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        int w, r, d, rows, dens, cut, nfr, f, prev_w, start_q;
        bit cont;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // width zero acts as one, every pixel is its own row
        set_window(0, 0);
        queue_pixel(1'b1, 1'b1);
        queue_pixel(1'b0, 1'b0);
        queue_pixel(1'b1, 1'b0);
        queue_pixel(1'b1, 1'b0);
        settle();

        // fully set 3x3 frame, then a mixed one after a new frame start
        set_window(3, 1);
        queue_frame(3, 3, 100, 1'b1, 0);
        queue_frame(3, 3, 50, 1'b1, 0);
        settle();

        // window wider than the row, nothing comes out
        set_window(2, 1);
        queue_frame(2, 2, 100, 1'b1, 0);
        settle();

        // row width narrowed mid-frame, the open row ends at once
        set_window(8, 1);
        queue_frame(8, 4, 50, 1'b1, 29);
        settle();
        set_window(3, 1);
        queue_frame(3, 3, 60, 1'b0, 0);
        settle();

        // width above the maximum, one long row with no idling
        calm = 1'b1;
        set_window(4095, 0);
        queue_frame(300, 1, 50, 1'b1, 0);
        settle();
        calm = 1'b0;

        // largest window, all set
        set_window(33, MAXR);
        queue_frame(33, RING, 100, 1'b1, 0);
        settle();

        prev_w = 0;
        start_q = queued;
        while (queued - start_q < RANDOM_PIXELS) begin
            cont = (prev_w > 0) && ($urandom_range(4) == 0);
            if (cont)
                w = $urandom_range(1, prev_w);
            else if ($urandom_range(9) == 0)
                w = $urandom_range(41, 200);
            else
                w = $urandom_range(1, 40);
            if (w > 40)
                r = $urandom_range(0, 1);
            else if ($urandom_range(99) < 15)
                r = $urandom_range(0, MAXR);
            else
                r = $urandom_range(0, (w >= 7) ? 3 : (w - 1) / 2);
            d = 2 * r + 1;
            if (d <= w)
                rows = d + $urandom_range(0, (w > 40) ? 1 : 3);
            else
                rows = $urandom_range(1, 3);
            set_window(w, r);
            nfr = $urandom_range(1, 2);
            for (f = 0; f < nfr; f++) begin
                case ($urandom_range(5))
                    0: dens = 0;
                    1: dens = 100;
                    2: dens = 90;
                    3: dens = 50;
                    4: dens = 20;
                    default: dens = $urandom_range(0, 100);
                endcase
                cut = ($urandom_range(9) == 0) ? $urandom_range(1, w * rows) : 0;
                queue_frame(w, rows, dens, !(cont && f == 0), cut);
            end
            prev_w = w;
            settle();
        end

        $display("run: %0d pixels under %0d window settings, %0d windows checked, %0d fully set",
                 pixel_count, setting_count, result_count, full_count);
        $display("run: width clamps, narrowed rows, %0d-cycle output stall, %0d errors",
                 HOLD_CYCLES, error_count);
        if (error_count == 0)
            $display("PASS mask_window_erosion_top");
        else
            $display("FAIL mask_window_erosion_top");
        $finish;
    end

endmodule
